[src/frcp_pkg.sv]
package frcp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ACT_W = 2;
    localparam int unsigned ERR_W = 3;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] CMD_WRITE = 8'h57;
    localparam logic [BYTE_W-1:0] CMD_READ = 8'h52;
    localparam logic [BYTE_W-1:0] CMD_GET_ERR = 8'h45;

    localparam logic [ERR_W-1:0] ERR_NONE = 3'd0;
    localparam logic [ERR_W-1:0] ERR_START = 3'd1;
    localparam logic [ERR_W-1:0] ERR_END = 3'd2;
    localparam logic [ERR_W-1:0] ERR_CMD = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TIMEOUT = 3'd4;

    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TX = 2'd3;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] timeout_ticks;
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] end_code;
    } frcp_cfg_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] value;
    } frcp_result_t;

endpackage

[src/frcp_core.sv]
module frcp_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          func,
    input  logic [frcp_pkg::BYTE_W-1:0]   rx_byte,
    input  frcp_pkg::frcp_cfg_t           cfg,
    output frcp_pkg::frcp_result_t        result
);
    import frcp_pkg::*;

    localparam logic [PHASE_W-1:0] PH_START = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CMD = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ADDR = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd3;
    localparam logic [PHASE_W-1:0] PH_END = 3'd4;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [BYTE_W-1:0]  cmd_reg, cmd_next;
    logic [BYTE_W-1:0]  addr_reg, addr_next;
    logic [BYTE_W-1:0]  data_reg, data_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic [BYTE_W-1:0]  idle_reg, idle_next;
    logic [BYTE_W:0]    idle_inc;

    assign idle_inc = {1'b0, idle_reg} + {{BYTE_W{1'b0}}, 1'b1};

    always_comb begin
        phase_next = phase_reg;
        cmd_next = cmd_reg;
        addr_next = addr_reg;
        data_next = data_reg;
        err_next = err_reg;
        idle_next = idle_reg;
        result.action = ACT_NONE;
        result.reg_addr = '0;
        result.value = '0;
        if (func == FUNC_TICK) begin
            if (idle_inc >= {1'b0, cfg.timeout_ticks}) begin
                idle_next = '0;
                if (phase_reg != PH_START) begin
                    err_next = ERR_TIMEOUT;
                    phase_next = PH_START;
                end
            end else begin
                idle_next = idle_inc[BYTE_W-1:0];
            end
        end else begin
            idle_next = '0;
            case (phase_reg)
                PH_START: begin
                    if (rx_byte == cfg.start_code) begin
                        phase_next = PH_CMD;
                    end else begin
                        err_next = ERR_START;
                    end
                end
                PH_CMD: begin
                    cmd_next = rx_byte;
                    phase_next = PH_ADDR;
                end
                PH_ADDR: begin
                    addr_next = rx_byte;
                    phase_next = PH_DATA;
                end
                PH_DATA: begin
                    data_next = rx_byte;
                    phase_next = PH_END;
                end
                PH_END: begin
                    if (rx_byte == cfg.end_code) begin
                        if (cmd_reg == CMD_WRITE) begin
                            result.action = ACT_WRITE;
                            result.reg_addr = addr_reg;
                            result.value = data_reg;
                            err_next = ERR_NONE;
                        end else if (cmd_reg == CMD_READ) begin
                            result.action = ACT_READ;
                            result.reg_addr = addr_reg;
                            err_next = ERR_NONE;
                        end else if (cmd_reg == CMD_GET_ERR) begin
                            result.action = ACT_TX;
                            result.value = {{(BYTE_W-ERR_W){1'b0}}, err_reg};
                        end else begin
                            err_next = ERR_CMD;
                        end
                    end else begin
                        err_next = ERR_END;
                    end
                    phase_next = PH_START;
                end
                default: begin
                    phase_next = PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            cmd_reg <= '0;
            addr_reg <= '0;
            data_reg <= '0;
            err_reg <= ERR_NONE;
            idle_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            cmd_reg <= cmd_next;
            addr_reg <= addr_next;
            data_reg <= data_next;
            err_reg <= err_next;
            idle_reg <= idle_next;
        end
    end

endmodule

[src/framed_register_command_parser.sv]
// Parses five-byte command frames (start code, command, register, data, end code) from a
// stream of received bytes and timer ticks, tagged by s_tuser (0 byte, 1 tick). Every item
// gives exactly one result item: m_tuser is the action (0 none, 1 register write, 2 register
// read request, 3 transmit the last error code) and m_tdata carries register address and
// value. An item is taken into an input register and passes the parser logic into the output
// register once the output is free, so the block sustains one item per clock while m_tready
// is high; a stalled output holds its item while one more waits in the input register.
// Timeout period, start code and end code are written through the cfg port (index 0, 1, 2);
// the user must do so only while no item is in flight (unenforced); cfg_ready is always high.
module framed_register_command_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [frcp_pkg::BYTE_W-1:0]       s_tdata,   // rx_byte
    input  logic                              s_tuser,   // func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [2*frcp_pkg::BYTE_W-1:0]     m_tdata,   // value, reg_addr
    output logic [frcp_pkg::ACT_W-1:0]        m_tuser,   // action
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [frcp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [frcp_pkg::BYTE_W-1:0]       cfg_data
);
    import frcp_pkg::*;

    frcp_cfg_t          cfg_reg;
    logic               in_valid_reg;
    logic               in_func_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               out_valid_reg;
    frcp_result_t       out_reg;
    frcp_result_t       result;
    logic               advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks <= 8'd78;
            cfg_reg.start_code <= 8'h02;
            cfg_reg.end_code <= 8'h03;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_data;
                CFG_START: cfg_reg.start_code <= cfg_data;
                CFG_END: cfg_reg.end_code <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    frcp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .func    (in_func_reg),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser = out_reg.action;
    assign m_tdata = {out_reg.value, out_reg.reg_addr};

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg || m_tready) |-> s_tready)
        else $error("input stalled while output is free");

    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.action == ACT_NONE) |->
        (out_reg.reg_addr == '0 && out_reg.value == '0))
        else $error("empty action carries data");

    a_tx_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.action == ACT_TX) |->
        (out_reg.reg_addr == '0 && out_reg.value <= {{(BYTE_W-ERR_W){1'b0}}, ERR_TIMEOUT}))
        else $error("transmitted error code out of range");

    a_out_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without a pending input item");

endmodule
